// File: hdl/queue_stack_order_checker_defines.svh
// Assertion macros for the order checker.
`ifndef QUEUE_STACK_ORDER_CHECKER_DEFINES_SVH
`define QUEUE_STACK_ORDER_CHECKER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define QSOC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define QSOC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: hdl/qsoc_pkg.sv
package qsoc_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int KEY_BITS    = 32;
  localparam int KEY_W       = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int PTR_BITS    = $clog2(STORE_DEPTH);
  localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_TAKE = 2'd1,
    REQ_NEW  = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] item_key;
  } req_t;

  typedef struct packed {
    logic       queue_possible;
    logic       stack_possible;
    logic [1:0] fault;
  } res_t;

endpackage

// File: hdl/queue_stack_order_checker.sv
// Queue/stack order checker.
// Input channel req (req_valid/req_ready) carries one operation per item:
// put a key, take a key, or start a new case. Output channel res
// (res_valid/res_ready) returns one item per operation: whether the trace
// so far still fits queue order, whether it fits stack order, and a fault
// code (take from empty, put into full).
// Keys live in two single-port synchronous memories, a ring queue and a
// stack, each read through an output register.
// Put, new case and unused codes give their result on the cycle after
// acceptance; a take reads both memories into registers, and the lookup
// state compares and registers its result. Puts go at one item per cycle
// while the output drains; a take holds off the next item until lookup.
// A result waits in the output register while res_ready is low; req_ready
// stays high as long as that register drains in the same cycle. req_ready
// is low during reset and during the lookup cycle of a take.
// Reset empties both structures and sets both flags; memory contents are
// not cleared and need no clearing pass.
`include "queue_stack_order_checker_defines.svh"

module queue_stack_order_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  qsoc_pkg::req_t   req,
  output logic             res_valid,
  input  logic             res_ready,
  output qsoc_pkg::res_t   res
);

  logic [qsoc_pkg::KEY_W-1:0] fifo_mem [qsoc_pkg::STORE_DEPTH];
  logic [qsoc_pkg::KEY_W-1:0] lifo_mem [qsoc_pkg::STORE_DEPTH];
  logic [qsoc_pkg::KEY_W-1:0] fifo_rd_data;
  logic [qsoc_pkg::KEY_W-1:0] lifo_rd_data;
  logic [qsoc_pkg::KEY_W-1:0] take_key;
  logic [qsoc_pkg::KEY_W-1:0] in_key;

  qsoc_pkg::state_t state, state_next;

  logic [qsoc_pkg::PTR_BITS-1:0] fifo_rd_ptr, fifo_rd_ptr_next;
  logic [qsoc_pkg::PTR_BITS-1:0] fifo_wr_ptr, fifo_wr_ptr_next;
  logic [qsoc_pkg::CNT_BITS-1:0] fifo_count, fifo_count_next;
  logic [qsoc_pkg::CNT_BITS-1:0] lifo_depth, lifo_depth_next;
  logic [qsoc_pkg::PTR_BITS-1:0] lifo_top;
  logic fifo_ok, fifo_ok_next;
  logic lifo_ok, lifo_ok_next;
  logic res_valid_next;
  qsoc_pkg::res_t res_next;
  qsoc_pkg::fault_t fault_code;
  logic fifo_we, lifo_we, rd_en;
  logic fifo_full, lifo_full;

  assign in_key    = req.item_key[qsoc_pkg::KEY_W-1:0];
  assign lifo_top  = qsoc_pkg::PTR_BITS'(lifo_depth - qsoc_pkg::CNT_BITS'(1));
  assign fifo_full = (fifo_count == qsoc_pkg::CNT_BITS'(qsoc_pkg::STORE_DEPTH));
  assign lifo_full = (lifo_depth == qsoc_pkg::CNT_BITS'(qsoc_pkg::STORE_DEPTH));

  function automatic logic [qsoc_pkg::PTR_BITS-1:0] ring_next(
    input logic [qsoc_pkg::PTR_BITS-1:0] p
  );
    if (p == qsoc_pkg::PTR_BITS'(qsoc_pkg::STORE_DEPTH - 1)) begin
      return '0;
    end
    return p + qsoc_pkg::PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qsoc_pkg::S_IDLE;
      fifo_rd_ptr <= '0;
      fifo_wr_ptr <= '0;
      fifo_count  <= '0;
      lifo_depth  <= '0;
      fifo_ok     <= 1'b1;
      lifo_ok     <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fifo_rd_ptr <= fifo_rd_ptr_next;
      fifo_wr_ptr <= fifo_wr_ptr_next;
      fifo_count  <= fifo_count_next;
      lifo_depth  <= lifo_depth_next;
      fifo_ok     <= fifo_ok_next;
      lifo_ok     <= lifo_ok_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rd_en) begin
      take_key     <= in_key;
      fifo_rd_data <= fifo_mem[fifo_rd_ptr];
      lifo_rd_data <= lifo_mem[lifo_top];
    end
    if (fifo_we) begin
      fifo_mem[fifo_wr_ptr] <= in_key;
    end
    if (lifo_we) begin
      lifo_mem[lifo_depth[qsoc_pkg::PTR_BITS-1:0]] <= in_key;
    end
  end

  always_comb begin
    state_next       = state;
    fifo_rd_ptr_next = fifo_rd_ptr;
    fifo_wr_ptr_next = fifo_wr_ptr;
    fifo_count_next  = fifo_count;
    lifo_depth_next  = lifo_depth;
    fifo_ok_next     = fifo_ok;
    lifo_ok_next     = lifo_ok;
    res_valid_next   = res_valid && !res_ready;
    res_next         = res;
    fault_code       = qsoc_pkg::FAULT_NONE;
    fifo_we          = 1'b0;
    lifo_we          = 1'b0;
    rd_en            = 1'b0;
    req_ready        = 1'b0;
    unique case (state)
      qsoc_pkg::S_IDLE: begin
        req_ready = !rst && (!res_valid || res_ready);
        if (req_valid && req_ready) begin
          case (req.req_type)
            qsoc_pkg::REQ_NEW: begin
              fifo_rd_ptr_next = '0;
              fifo_wr_ptr_next = '0;
              fifo_count_next  = '0;
              lifo_depth_next  = '0;
              fifo_ok_next     = 1'b1;
              lifo_ok_next     = 1'b1;
            end
            qsoc_pkg::REQ_PUT: begin
              if (fifo_ok) begin
                if (fifo_full) begin
                  fifo_ok_next = 1'b0;
                  fault_code   = qsoc_pkg::FAULT_FULL;
                end else begin
                  fifo_we          = 1'b1;
                  fifo_wr_ptr_next = ring_next(fifo_wr_ptr);
                  fifo_count_next  = fifo_count + qsoc_pkg::CNT_BITS'(1);
                end
              end
              if (lifo_ok) begin
                if (lifo_full) begin
                  lifo_ok_next = 1'b0;
                  fault_code   = qsoc_pkg::FAULT_FULL;
                end else begin
                  lifo_we         = 1'b1;
                  lifo_depth_next = lifo_depth + qsoc_pkg::CNT_BITS'(1);
                end
              end
            end
            qsoc_pkg::REQ_TAKE: begin
              rd_en      = 1'b1;
              state_next = qsoc_pkg::S_LOOKUP;
            end
            default: ;
          endcase
          if (req.req_type != qsoc_pkg::REQ_TAKE) begin
            res_valid_next = 1'b1;
            res_next = '{queue_possible: fifo_ok_next, stack_possible: lifo_ok_next,
                         fault: fault_code};
          end
        end
      end
      qsoc_pkg::S_LOOKUP: begin
        if (fifo_ok) begin
          if (fifo_count == '0) begin
            fifo_ok_next = 1'b0;
            fault_code   = qsoc_pkg::FAULT_EMPTY;
          end else begin
            fifo_ok_next     = (fifo_rd_data == take_key);
            fifo_rd_ptr_next = ring_next(fifo_rd_ptr);
            fifo_count_next  = fifo_count - qsoc_pkg::CNT_BITS'(1);
          end
        end
        if (lifo_ok) begin
          if (lifo_depth == '0) begin
            lifo_ok_next = 1'b0;
            fault_code   = qsoc_pkg::FAULT_EMPTY;
          end else begin
            lifo_ok_next    = (lifo_rd_data == take_key);
            lifo_depth_next = lifo_depth - qsoc_pkg::CNT_BITS'(1);
          end
        end
        res_valid_next = 1'b1;
        res_next = '{queue_possible: fifo_ok_next, stack_possible: lifo_ok_next,
                     fault: fault_code};
        state_next = qsoc_pkg::S_IDLE;
      end
      default: state_next = qsoc_pkg::S_IDLE;
    endcase
  end

  `QSOC_NEVER(a_fifo_count_range, fifo_count > qsoc_pkg::CNT_BITS'(qsoc_pkg::STORE_DEPTH), "queue count overrun")
  `QSOC_NEVER(a_lifo_depth_range, lifo_depth > qsoc_pkg::CNT_BITS'(qsoc_pkg::STORE_DEPTH), "stack depth overrun")
  `QSOC_CHECK(a_lookup_slot_free, (state == qsoc_pkg::S_LOOKUP) |-> !res_valid, "output busy during lookup")
  `QSOC_CHECK(a_lookup_result, (state == qsoc_pkg::S_LOOKUP) |=> res_valid, "take result missing")
  `QSOC_CHECK(a_new_case_clears, (req_valid && req_ready && req.req_type == qsoc_pkg::REQ_NEW) |=> (fifo_count == '0 && lifo_depth == '0 && res.queue_possible && res.stack_possible), "new case not cleared")

endmodule

// File: tb/sv/queue_stack_order_checker_tb.sv
`timescale 1ns / 1ps

module queue_stack_order_checker_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  qsoc_pkg::req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  qsoc_pkg::res_t res;

  int idle_pct = 23;
  int n_sent = 0;
  int n_items = 0;
  int n_verdicts = 0;
  int n_empty = 0;
  int n_full = 0;
  int n_fail = 0;
  int n_cycles = 0;

  // shadow of the checker state
  logic [31:0] q_mem [qsoc_pkg::STORE_DEPTH];
  logic [qsoc_pkg::PTR_BITS-1:0] q_rd = '0;
  logic [qsoc_pkg::PTR_BITS-1:0] q_wr = '0;
  logic [qsoc_pkg::CNT_BITS-1:0] q_cnt = '0;
  logic [31:0] s_mem [qsoc_pkg::STORE_DEPTH];
  logic [qsoc_pkg::CNT_BITS-1:0] s_top = '0;
  logic q_fit = 1'b1;
  logic s_fit = 1'b1;

  qsoc_pkg::res_t pending_verdicts[$];

  queue_stack_order_checker i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [qsoc_pkg::PTR_BITS-1:0] ring_step(
    logic [qsoc_pkg::PTR_BITS-1:0] p
  );
    return (p == qsoc_pkg::PTR_BITS'(qsoc_pkg::STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic qsoc_pkg::res_t judge_item(qsoc_pkg::req_t item);
    qsoc_pkg::res_t r;
    r.fault = qsoc_pkg::FAULT_NONE;
    case (item.req_type)
      qsoc_pkg::REQ_NEW: begin
        q_rd = '0;
        q_wr = '0;
        q_cnt = '0;
        s_top = '0;
        q_fit = 1'b1;
        s_fit = 1'b1;
      end
      qsoc_pkg::REQ_PUT: begin
        if (q_fit) begin
          if (q_cnt >= qsoc_pkg::STORE_DEPTH) begin
            q_fit = 1'b0;
            r.fault = qsoc_pkg::FAULT_FULL;
          end else begin
            q_mem[q_wr] = item.item_key;
            q_wr = ring_step(q_wr);
            q_cnt = q_cnt + 1'b1;
          end
        end
        if (s_fit) begin
          if (s_top >= qsoc_pkg::STORE_DEPTH) begin
            s_fit = 1'b0;
            r.fault = qsoc_pkg::FAULT_FULL;
          end else begin
            s_mem[s_top[qsoc_pkg::PTR_BITS-1:0]] = item.item_key;
            s_top = s_top + 1'b1;
          end
        end
      end
      qsoc_pkg::REQ_TAKE: begin
        if (q_fit) begin
          if (q_cnt == 0) begin
            q_fit = 1'b0;
            r.fault = qsoc_pkg::FAULT_EMPTY;
          end else begin
            if (q_mem[q_rd] != item.item_key) q_fit = 1'b0;
            q_rd = ring_step(q_rd);
            q_cnt = q_cnt - 1'b1;
          end
        end
        if (s_fit) begin
          if (s_top == 0) begin
            s_fit = 1'b0;
            r.fault = qsoc_pkg::FAULT_EMPTY;
          end else begin
            s_top = s_top - 1'b1;
            if (s_mem[s_top[qsoc_pkg::PTR_BITS-1:0]] != item.item_key) s_fit = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.queue_possible = q_fit;
    r.stack_possible = s_fit;
    return r;
  endfunction

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : check_p
    qsoc_pkg::res_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        pending_verdicts.push_back(judge_item(req));
        n_items++;
      end
      if (res_valid && res_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with no item pending");
          n_fail++;
        end else begin
          want = pending_verdicts.pop_front();
          n_verdicts++;
          if (want.fault == qsoc_pkg::FAULT_EMPTY) n_empty++;
          if (want.fault == qsoc_pkg::FAULT_FULL) n_full++;
          if (res.queue_possible !== want.queue_possible) begin
            $error("queue_possible: expected %0b, actual %0b",
                   want.queue_possible, res.queue_possible);
            n_fail++;
          end
          if (res.stack_possible !== want.stack_possible) begin
            $error("stack_possible: expected %0b, actual %0b",
                   want.stack_possible, res.stack_possible);
            n_fail++;
          end
          if (res.fault !== want.fault) begin
            $error("fault: expected %0d, actual %0d", want.fault, res.fault);
            n_fail++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               n_cycles, pending_verdicts.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] code, input logic [31:0] key);
    qsoc_pkg::req_t item;
    item.req_type = code;
    item.item_key = key;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_key();
    return $urandom_range(1) ? $urandom : $urandom_range(3);
  endfunction

  task automatic test_empty_take();
    send_item(qsoc_pkg::REQ_TAKE, 32'h0);
    send_item(qsoc_pkg::REQ_TAKE, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_PUT, 32'h1234_5678);
  endtask

  task automatic test_key_extremes();
    send_item(qsoc_pkg::REQ_NEW, 32'h0);
    send_item(qsoc_pkg::REQ_PUT, 32'h0000_0000);
    send_item(qsoc_pkg::REQ_PUT, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_PUT, 32'h5555_5555);
    send_item(qsoc_pkg::REQ_PUT, 32'hAAAA_AAAA);
    send_item(qsoc_pkg::REQ_TAKE, 32'h0000_0000);
    send_item(qsoc_pkg::REQ_TAKE, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_TAKE, 32'h5555_5555);
    send_item(qsoc_pkg::REQ_TAKE, 32'hAAAA_AAAA);
    send_item(qsoc_pkg::REQ_NEW, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_PUT, 32'h1);
    send_item(qsoc_pkg::REQ_PUT, 32'h2);
    send_item(qsoc_pkg::REQ_TAKE, 32'h2);
    send_item(qsoc_pkg::REQ_TAKE, 32'h1);
    send_item(qsoc_pkg::REQ_NEW, 32'h0);
    send_item(qsoc_pkg::REQ_PUT, 32'h7);
    send_item(REQ_UNUSED, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_TAKE, 32'h7);
    send_item(qsoc_pkg::REQ_TAKE, 32'h7);
    send_item(qsoc_pkg::REQ_PUT, 32'h9);
    send_item(qsoc_pkg::REQ_NEW, 32'h0);
  endtask

  task automatic test_capacity();
    logic [31:0] first_key;
    first_key = $urandom;
    send_item(qsoc_pkg::REQ_NEW, 32'h0);
    for (int i = 0; i < qsoc_pkg::STORE_DEPTH; i++) send_item(qsoc_pkg::REQ_PUT, $urandom);
    send_item(qsoc_pkg::REQ_PUT, $urandom);
    send_item(qsoc_pkg::REQ_NEW, 32'h0);
    send_item(qsoc_pkg::REQ_PUT, first_key);
    for (int i = 1; i < qsoc_pkg::STORE_DEPTH; i++) begin
      send_item(qsoc_pkg::REQ_PUT, first_key ^ i);
    end
    send_item(qsoc_pkg::REQ_TAKE, first_key);
    send_item(qsoc_pkg::REQ_PUT, 32'hFFFF_FFFF);
    send_item(qsoc_pkg::REQ_PUT, 32'h0);
  endtask

  task automatic run_case();
    logic [31:0] held[$];
    logic [31:0] key;
    int style;
    int n_ops;
    style = $urandom_range(3);
    send_item(qsoc_pkg::REQ_NEW, rand_key());
    if ($urandom_range(14) == 0) begin
      n_ops = $urandom_range(60, 66);
      for (int i = 0; i < n_ops; i++) begin
        key = rand_key();
        held.push_back(key);
        send_item(qsoc_pkg::REQ_PUT, key);
      end
      while (held.size() != 0) begin
        key = (style == 1) ? held.pop_back() : held.pop_front();
        send_item(qsoc_pkg::REQ_TAKE, key);
      end
    end else begin
      n_ops = $urandom_range(2, 16);
      for (int i = 0; i < n_ops; i++) begin
        if (style == 3) begin
          send_item(2'($urandom_range(3)), rand_key());
        end else if (held.size() == 0 || $urandom_range(99) < 55) begin
          if (held.size() == 0 && $urandom_range(9) == 0) begin
            send_item(qsoc_pkg::REQ_TAKE, rand_key());
          end else begin
            key = rand_key();
            held.push_back(key);
            send_item(qsoc_pkg::REQ_PUT, key);
          end
        end else begin
          if (style == 0 || (style == 2 && $urandom_range(1) == 0))
            key = held.pop_front();
          else
            key = held.pop_back();
          if ($urandom_range(7) == 0) key = key ^ (32'h1 << $urandom_range(31));
          send_item(qsoc_pkg::REQ_TAKE, key);
        end
      end
      if ($urandom_range(3) == 0) begin
        while (held.size() != 0) begin
          key = (style == 0) ? held.pop_front() : held.pop_back();
          send_item(qsoc_pkg::REQ_TAKE, key);
        end
        send_item(qsoc_pkg::REQ_TAKE, rand_key());
      end
    end
  endtask

  task automatic test_random_cases(input int upto);
    while (n_sent < upto) run_case();
  endtask

  task automatic test_back_to_back(input int n);
    int stop_at;
    stop_at = n_sent + n;
    idle_pct = 0;
    while (n_sent < stop_at) run_case();
    idle_pct = 23;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_take();
    test_key_extremes();
    test_capacity();
    test_random_cases(500);
    test_back_to_back(150);
    test_random_cases(ITEM_TARGET);
    req_valid <= 1'b0;
    while (n_verdicts < n_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0 || n_items != n_sent) begin
      $error("items unaccounted for: %0d sent, %0d accepted, %0d results pending",
             n_sent, n_items, pending_verdicts.size());
      n_fail++;
    end
    $display("run covered %0d items over %0d cycles, %0d results checked",
             n_items, n_cycles, n_verdicts);
    $display("faults seen: %0d take from empty, %0d put into full", n_empty, n_full);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/qsoc_pkg.sv
hdl/queue_stack_order_checker.sv
tb/sv/queue_stack_order_checker_tb.sv
